FILE: rtl/krt_pkg.sv
// shared types and constants of the keyed registration table
// no dependencies
package krt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int BATCH_DEPTH_DEF = 32;

    localparam int KEY_W   = 32;
    localparam int ATTR_W  = 64;
    localparam int COUNT_W = 6;

    // flag bit positions inside the 32-bit flags word
    localparam int FLAG_REMOVE_BIT = 0;
    localparam int FLAG_SINK_BIT   = 8;
    localparam int FLAG_NOTIFY_BIT = 13;

    typedef logic [1:0] t_code;

    localparam t_code KIND_STATUS = 2'd0;
    localparam t_code KIND_ENTRY  = 2'd1;
    localparam t_code KIND_NOTICE = 2'd2;

    localparam t_code ST_OK          = 2'd0;
    localparam t_code ST_INVALID_PAR = 2'd1;
    localparam t_code ST_NO_MEMORY   = 2'd2;
    localparam t_code ST_SHORT_BUF   = 2'd3;

    // result of the shared key compare unit
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

FILE: rtl/krt_key_cmp.sv
// shared key compare unit: equality and unsigned less-than of two keys
// depends on krt_pkg
module krt_key_cmp (
    input  logic [krt_pkg::KEY_W-1:0] i_a,
    input  logic [krt_pkg::KEY_W-1:0] i_b,
    output krt_pkg::t_cmp             o_res
);
    import krt_pkg::*;

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

FILE: rtl/keyed_registration_table.sv
// keyed registration table: batch buffer, keyed table and a sequencer around one compare unit
// depends on krt_pkg and krt_key_cmp
// a register record that is not last is taken at once and busy stays low; a batch end
//   searches the table for each buffered record and, on a delete, shifts the entries above
//   down; a list emits only a status when only a status is due, else one entry per pass
//   in ascending key order; each result is on the ports in the cycle after its state
// one item is handled at a time; busy drops as the final status transfer is registered
// reset (synchronous, active low) clears count, batch fill and bad mark; memories keep no reset
module keyed_registration_table #(
    parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
    parameter int BATCH_DEPTH = krt_pkg::BATCH_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [15:0]                 i_usage_page,
    input  logic [15:0]                 i_usage,
    input  logic [31:0]                 i_flags,
    input  logic [31:0]                 i_target,
    input  logic                        i_last_in_batch,
    input  logic                        i_count_only,
    input  logic [15:0]                 i_capacity,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic [1:0]                  o_status,
    output logic [krt_pkg::COUNT_W-1:0] o_count,
    output logic [15:0]                 o_out_usage_page,
    output logic [15:0]                 o_out_usage,
    output logic [31:0]                 o_out_flags,
    output logic [31:0]                 o_out_target,
    output logic                        o_last
);
    import krt_pkg::*;

    // table index and count widths
    localparam int TW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    // batch index and fill widths
    localparam int BIW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
    localparam int BFW = $clog2(BATCH_DEPTH + 1);

    // sequencer states, one-hot
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_B_RD  = 13'b0000000000010,  // fetch next batch record
        S_S_RD  = 13'b0000000000100,  // search: read table entry
        S_S_CMP = 13'b0000000001000,  // search: compare against record key
        S_SH_RD = 13'b0000000010000,  // delete: read the entry above
        S_SH_WR = 13'b0000000100000,  // delete: move it down
        S_L_PAS = 13'b0000001000000,  // list: start one selection pass
        S_LS_RD = 13'b0000010000000,  // list: read candidate
        S_LS_C1 = 13'b0000100000000,  // list: candidate above last listed key
        S_LS_C2 = 13'b0001000000000,  // list: candidate below best so far
        S_LE_RD = 13'b0010000000000,  // list: read chosen entry
        S_LE_OT = 13'b0100000000000,  // list: emit chosen entry
        S_FIN   = 13'b1000000000000   // emit final status
    } t_state;

    t_state r_state, n_state;

    // table memory
    logic [KEY_W-1:0]  r_tkey  [TABLE_DEPTH];
    logic [ATTR_W-1:0] r_tattr [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_rd_key;
    logic [ATTR_W-1:0] r_rd_attr;

    // batch memory
    logic [KEY_W-1:0]  r_bkey  [BATCH_DEPTH];
    logic [ATTR_W-1:0] r_battr [BATCH_DEPTH];
    logic [KEY_W-1:0]  r_rec_key;
    logic [ATTR_W-1:0] r_rec_attr;

    // control state
    logic [CW-1:0]  r_count, n_count;
    logic [BFW-1:0] r_fill, n_fill;
    logic           r_bad, n_bad;
    logic [BFW-1:0] r_b, n_b;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_pass, n_pass;
    t_code          r_status, n_status;
    logic           r_have_prev, n_have_prev;
    logic           r_have_best, n_have_best;
    logic [KEY_W-1:0] r_prev, n_prev;
    logic [KEY_W-1:0] r_best, n_best;
    logic [TW-1:0]  r_best_idx, n_best_idx;

    // output registers
    logic               r_o_valid, n_o_valid;
    t_code              r_o_kind, n_o_kind;
    t_code              r_o_status, n_o_status;
    logic [CW-1:0]      r_o_count, n_o_count;
    logic [KEY_W-1:0]   r_o_key, n_o_key;
    logic [ATTR_W-1:0]  r_o_attr, n_o_attr;
    logic               r_o_last, n_o_last;

    // memory port controls
    logic              w_wr_en;
    logic [TW-1:0]     w_wr_addr;
    logic [KEY_W-1:0]  w_wr_key;
    logic [ATTR_W-1:0] w_wr_attr;
    logic [TW-1:0]     w_rd_addr;
    logic              w_bwr_en;
    logic              w_brd_en;

    // shared compare unit
    logic [KEY_W-1:0] w_cmp_b;
    t_cmp             w_cmp;

    logic              w_accept;
    logic [CW-1:0]     w_idx_inc;
    logic              w_rec_remove;
    logic              w_rec_notify;
    logic              w_in_bad;
    logic              w_batch_full;

    assign w_accept     = start && !busy;
    assign w_idx_inc    = r_idx + 1'b1;
    assign w_rec_remove = r_rec_attr[KEY_W + FLAG_REMOVE_BIT];
    // notice for an applied record with notify and a nonzero target
    assign w_rec_notify = r_rec_attr[KEY_W + FLAG_NOTIFY_BIT] && (r_rec_attr[31:0] != '0);
    assign w_in_bad     = (i_flags[FLAG_SINK_BIT] && (i_target == '0)) ||
                          (i_flags[FLAG_REMOVE_BIT] && (i_target != '0));
    assign w_batch_full = (r_fill == BFW'(BATCH_DEPTH));

    always_comb begin
        case (r_state)
            S_LS_C1: w_cmp_b = r_prev;
            S_LS_C2: w_cmp_b = r_best;
            default: w_cmp_b = r_rec_key;
        endcase
    end

    krt_key_cmp u_cmp (
        .i_a   (r_rd_key),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_tkey[w_wr_addr]  <= w_wr_key;
            r_tattr[w_wr_addr] <= w_wr_attr;
        end
        r_rd_key  <= r_tkey[w_rd_addr];
        r_rd_attr <= r_tattr[w_rd_addr];
    end

    // batch memory: written on each buffered record, read once per applied record
    always_ff @(posedge i_clk) begin
        if (w_bwr_en) begin
            r_bkey[r_fill[BIW-1:0]]  <= {i_usage_page, i_usage};
            r_battr[r_fill[BIW-1:0]] <= {i_flags, i_target};
        end
        if (w_brd_en) begin
            r_rec_key  <= r_bkey[r_b[BIW-1:0]];
            r_rec_attr <= r_battr[r_b[BIW-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_fill      = r_fill;
        n_bad       = r_bad;
        n_b         = r_b;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_status    = r_status;
        n_have_prev = r_have_prev;
        n_have_best = r_have_best;
        n_prev      = r_prev;
        n_best      = r_best;
        n_best_idx  = r_best_idx;

        n_o_valid  = 1'b0;
        n_o_kind   = r_o_kind;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_key    = r_o_key;
        n_o_attr   = r_o_attr;
        n_o_last   = r_o_last;

        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[TW-1:0];
        w_wr_key  = r_rec_key;
        w_wr_attr = r_rec_attr;
        w_rd_addr = r_idx[TW-1:0];
        w_bwr_en  = 1'b0;
        w_brd_en  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command) begin
                        // list request
                        n_state = S_FIN;
                        if (i_count_only) begin
                            n_status = ST_OK;
                        end else if (i_capacity == '0) begin
                            n_status = ST_INVALID_PAR;
                        end else if (i_capacity < 16'(r_count)) begin
                            n_status = ST_SHORT_BUF;
                        end else begin
                            n_pass      = '0;
                            n_have_prev = 1'b0;
                            n_state     = S_L_PAS;
                        end
                    end else begin
                        // register record: buffer it, an invalid record or overflow marks the batch bad
                        n_bad = r_bad || w_in_bad || w_batch_full;
                        if (!w_batch_full) begin
                            w_bwr_en = 1'b1;
                            n_fill   = r_fill + 1'b1;
                        end
                        if (i_last_in_batch) begin
                            if (n_bad) begin
                                n_status = ST_INVALID_PAR;
                                n_state  = S_FIN;
                            end else begin
                                n_b     = '0;
                                n_state = S_B_RD;
                            end
                        end
                    end
                end
            end
            S_B_RD: begin
                if (r_b == r_fill) begin
                    n_status = ST_OK;
                    n_state  = S_FIN;
                end else begin
                    w_brd_en = 1'b1;
                    n_idx    = '0;
                    n_state  = S_S_RD;
                end
            end
            S_S_RD: begin
                if (r_idx == r_count) begin
                    // key absent
                    if (w_rec_remove) begin
                        n_b     = r_b + 1'b1;
                        n_state = S_B_RD;
                    end else if (r_count == CW'(TABLE_DEPTH)) begin
                        n_status = ST_NO_MEMORY;
                        n_state  = S_FIN;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_count[TW-1:0];
                        n_count   = r_count + 1'b1;
                        n_b       = r_b + 1'b1;
                        n_state   = S_B_RD;
                        if (w_rec_notify) begin
                            n_o_valid  = 1'b1;
                            n_o_kind   = KIND_NOTICE;
                            n_o_status = ST_OK;
                            n_o_count  = n_count;
                            n_o_key    = r_rec_key;
                            n_o_attr   = r_rec_attr;
                            n_o_last   = 1'b0;
                        end
                    end
                end else begin
                    n_state = S_S_CMP;
                end
            end
            S_S_CMP: begin
                if (w_cmp.eq) begin
                    if (w_rec_remove) begin
                        n_state = S_SH_RD;
                    end else begin
                        // overwrite the matching entry
                        w_wr_en = 1'b1;
                        n_b     = r_b + 1'b1;
                        n_state = S_B_RD;
                        if (w_rec_notify) begin
                            n_o_valid  = 1'b1;
                            n_o_kind   = KIND_NOTICE;
                            n_o_status = ST_OK;
                            n_o_count  = r_count;
                            n_o_key    = r_rec_key;
                            n_o_attr   = r_rec_attr;
                            n_o_last   = 1'b0;
                        end
                    end
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_S_RD;
                end
            end
            S_SH_RD: begin
                if (w_idx_inc < r_count) begin
                    w_rd_addr = w_idx_inc[TW-1:0];
                    n_state   = S_SH_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_b     = r_b + 1'b1;
                    n_state = S_B_RD;
                end
            end
            S_SH_WR: begin
                w_wr_en   = 1'b1;
                w_wr_key  = r_rd_key;
                w_wr_attr = r_rd_attr;
                n_idx     = w_idx_inc;
                n_state   = S_SH_RD;
            end
            S_L_PAS: begin
                if (r_pass == r_count) begin
                    n_status = ST_OK;
                    n_state  = S_FIN;
                end else begin
                    n_idx       = '0;
                    n_have_best = 1'b0;
                    n_state     = S_LS_RD;
                end
            end
            S_LS_RD: begin
                if (r_idx == r_count) begin
                    n_state = S_LE_RD;
                end else begin
                    n_state = S_LS_C1;
                end
            end
            S_LS_C1: begin
                // keys are unique, so the next key in order is the least one above the last
                if (!r_have_prev || (!w_cmp.lt && !w_cmp.eq)) begin
                    n_state = S_LS_C2;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_LS_RD;
                end
            end
            S_LS_C2: begin
                if (!r_have_best || w_cmp.lt) begin
                    n_have_best = 1'b1;
                    n_best      = r_rd_key;
                    n_best_idx  = r_idx[TW-1:0];
                end
                n_idx   = w_idx_inc;
                n_state = S_LS_RD;
            end
            S_LE_RD: begin
                w_rd_addr = r_best_idx;
                n_state   = S_LE_OT;
            end
            S_LE_OT: begin
                n_o_valid   = 1'b1;
                n_o_kind    = KIND_ENTRY;
                n_o_status  = ST_OK;
                n_o_count   = r_count;
                n_o_key     = r_rd_key;
                n_o_attr    = r_rd_attr;
                n_o_last    = 1'b0;
                n_prev      = r_rd_key;
                n_have_prev = 1'b1;
                n_pass      = r_pass + 1'b1;
                n_state     = S_L_PAS;
            end
            S_FIN: begin
                n_o_valid  = 1'b1;
                n_o_kind   = KIND_STATUS;
                n_o_status = r_status;
                n_o_count  = r_count;
                n_o_key    = '0;
                n_o_attr   = '0;
                n_o_last   = 1'b1;
                // a list leaves an open batch untouched
                if (r_b != '0 || r_fill != '0) begin
                    n_fill = r_fill;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // batch bookkeeping ends with any batch close; lists skip it
    logic r_in_batch, n_in_batch;

    always_comb begin
        n_in_batch = r_in_batch;
        if (r_state == S_IDLE && w_accept) begin
            n_in_batch = !i_command && i_last_in_batch;
        end else if (r_state == S_FIN) begin
            n_in_batch = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_fill     <= '0;
            r_bad      <= 1'b0;
            r_o_valid  <= 1'b0;
            r_in_batch <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_o_valid  <= n_o_valid;
            r_in_batch <= n_in_batch;
            if (r_state == S_FIN && r_in_batch) begin
                r_fill <= '0;
                r_bad  <= 1'b0;
            end else begin
                r_fill <= n_fill;
                r_bad  <= n_bad;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_b         <= n_b;
        r_idx       <= n_idx;
        r_pass      <= n_pass;
        r_status    <= n_status;
        r_have_prev <= n_have_prev;
        r_have_best <= n_have_best;
        r_prev      <= n_prev;
        r_best      <= n_best;
        r_best_idx  <= n_best_idx;
        r_o_kind    <= n_o_kind;
        r_o_status  <= n_o_status;
        r_o_count   <= n_o_count;
        r_o_key     <= n_o_key;
        r_o_attr    <= n_o_attr;
        r_o_last    <= n_o_last;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_status         = r_o_status;
    assign o_count          = COUNT_W'(r_o_count);
    assign o_out_usage_page = r_o_key[31:16];
    assign o_out_usage      = r_o_key[15:0];
    assign o_out_flags      = r_o_attr[63:32];
    assign o_out_target     = r_o_attr[31:0];
    assign o_last           = r_o_last;

endmodule
